[rtl/stepper_phase_sequencer_macros.svh]
// ---------------------------------------------------------------------------
// Stepper phase sequencer assertion macros
// Concurrent assertion wrappers clocked on the block clock; they compile
// away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// check a property at every clock edge outside reset
`define SPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stepper phase sequencer assertion failed");
// check a property at every clock edge, reset included
`define SPS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("stepper phase sequencer assertion failed");
`else
`define SPS_ASSERT(lbl, clk, rst, prop)
`define SPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/sps_pkg.sv]
// ---------------------------------------------------------------------------
// Stepper phase sequencer package
// Widths, register indexes, phase tables and the shared control structs.
// ---------------------------------------------------------------------------
package sps_pkg;

   localparam int TIME_WIDTH     = 32;
   localparam int NOW_WIDTH      = 32;
   localparam int PERIOD_WIDTH   = 32;
   localparam int COUNT_WIDTH    = 31;
   localparam int PHASE_WIDTH    = 4;
   localparam int PIN_WIDTH      = 5;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PHASE_MODE   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PULSE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MOVE_COUNT   = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MOVE_DIR     = 2'd3;

   // phase modes
   localparam logic MODE_FOUR = 1'b0;
   localparam logic MODE_TEN  = 1'b1;

   localparam logic [PHASE_WIDTH-1:0] PHASES_TEN = 4'd10;

   // pins: bit0 step, bit1 dir, bit2 ms1, bit3 ms2, bit4 ms3
   localparam logic [PIN_WIDTH-1:0] MS_PIN_MASK = 5'b11100;

   typedef struct packed {
      logic                   mode;
      logic                   dir;
      logic [PHASE_WIDTH-1:0] phase;
      logic [PIN_WIDTH-1:0]   pins;
   } step_req_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic [PIN_WIDTH-1:0]   pins;
   } step_rsp_type;

   // step/dir levels for the four-phase pattern
   function automatic logic [1:0] four_phase_pins(input logic [1:0] p);
      logic [1:0] lv;
      unique case (p)
         2'd0:    lv = 2'd2;
         2'd1:    lv = 2'd3;
         2'd2:    lv = 2'd1;
         default: lv = 2'd0;
      endcase
      return lv;
   endfunction

   // five-pin levels for the ten-phase pattern
   function automatic logic [PIN_WIDTH-1:0] ten_phase_pins(input logic [PHASE_WIDTH-1:0] p);
      logic [PIN_WIDTH-1:0] lv;
      unique case (p)
         4'd0:    lv = 5'd21;
         4'd1:    lv = 5'd17;
         4'd2:    lv = 5'd25;
         4'd3:    lv = 5'd9;
         4'd4:    lv = 5'd11;
         4'd5:    lv = 5'd10;
         4'd6:    lv = 5'd14;
         4'd7:    lv = 5'd6;
         4'd8:    lv = 5'd22;
         default: lv = 5'd20;
      endcase
      return lv;
   endfunction

endpackage

[rtl/sps_phase_step.sv]
// ---------------------------------------------------------------------------
// Stepper phase sequencer phase step
// Advances the phase one place in the chosen direction, modulo the phase
// count of the mode, and looks up the pin levels of the new phase.
// ---------------------------------------------------------------------------
module sps_phase_step (
   input  sps_pkg::step_req_type step_req,
   output sps_pkg::step_rsp_type step_rsp
);

   logic [1:0]                      four_next;
   logic [sps_pkg::PHASE_WIDTH:0]   ten_sum;
   logic [sps_pkg::PHASE_WIDTH-1:0] ten_next;

   // four phases: modulo four is the low two bits
   assign four_next = step_req.dir ? (step_req.phase[1:0] + 2'd1)
                                   : (step_req.phase[1:0] - 2'd1);

   // ten phases: add one or nine, then fold back into range
   assign ten_sum = {1'b0, step_req.phase}
                  + (step_req.dir ? 5'd1 : 5'd9);

   always_comb begin
      priority if (ten_sum >= 5'd20) begin
         ten_next = 4'(ten_sum - 5'd20);
      end else if (ten_sum >= {1'b0, sps_pkg::PHASES_TEN}) begin
         ten_next = 4'(ten_sum - {1'b0, sps_pkg::PHASES_TEN});
      end else begin
         ten_next = ten_sum[sps_pkg::PHASE_WIDTH-1:0];
      end
   end

   // select phase and pins for the mode; four-phase keeps the ms pins
   always_comb begin
      if (step_req.mode == sps_pkg::MODE_TEN) begin
         step_rsp.phase = ten_next;
         step_rsp.pins  = sps_pkg::ten_phase_pins(ten_next);
      end else begin
         step_rsp.phase = {2'b00, four_next};
         step_rsp.pins  = (step_req.pins & sps_pkg::MS_PIN_MASK)
                        | {3'b000, sps_pkg::four_phase_pins(four_next)};
      end
   end

endmodule

[rtl/stepper_phase_sequencer.sv]
// ---------------------------------------------------------------------------
// Stepper phase sequencer
// Issues timed stepper phase steps against a microsecond time stamp.
// ---------------------------------------------------------------------------
// One time stamp is taken per clock while results are taken, since the step
// compare, phase advance and table lookup all sit between the input register,
// loaded at acceptance, and the result register, loaded as the input stage
// advances; each stamp yields one result, held until taken. A step is issued
// when steps remain and the time stamp has reached the scheduled pulse time;
// the next pulse is then scheduled one period later (from now when the
// schedule is zero). Writing move_count loads the step count and restarts the
// schedule. Registers are to be written only while no transaction is in
// flight; the block does not enforce it.
module stepper_phase_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sps_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [sps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sps_pkg::NOW_WIDTH-1:0]       req_now_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_step_level,
   output logic                                rsp_dir_level,
   output logic                                rsp_ms1_level,
   output logic                                rsp_ms2_level,
   output logic                                rsp_ms3_level,
   output logic                                rsp_pulsed,
   output logic                                rsp_done_res
);

`include "stepper_phase_sequencer_macros.svh"

   // configuration
   logic                               mode_ff;
   logic [sps_pkg::PERIOD_WIDTH-1:0]   period_ff;
   logic                               dir_ff;

   // sequencer state
   logic [sps_pkg::PHASE_WIDTH-1:0]    phase_ff,     phase_in;
   logic [sps_pkg::COUNT_WIDTH-1:0]    remaining_ff, remaining_in;
   logic [sps_pkg::TIME_WIDTH-1:0]     next_time_ff, next_time_in;
   logic [sps_pkg::PIN_WIDTH-1:0]      pins_ff,      pins_in;

   // input stage
   logic                               s1_valid_ff;
   logic [sps_pkg::TIME_WIDTH-1:0]     s1_now_ff;

   // result stage
   logic                               rsp_valid_ff;
   logic [sps_pkg::PIN_WIDTH-1:0]      rsp_pins_ff;
   logic                               rsp_pulsed_ff, rsp_pulsed_in;
   logic                               rsp_done_ff,   rsp_done_in;

   logic                               advance;
   logic                               fire;
   logic [sps_pkg::PERIOD_WIDTH-1:0]   period_eff;
   logic [sps_pkg::TIME_WIDTH-1:0]     time_base;
   sps_pkg::step_req_type              step_req;
   sps_pkg::step_rsp_type              step_rsp;

   // handshake: result register drains, input stage refills behind it
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // step decision for the transaction in the input stage
   assign fire       = (remaining_ff != '0) && (s1_now_ff >= next_time_ff);
   assign period_eff = (period_ff == '0) ? sps_pkg::PERIOD_WIDTH'(1) : period_ff;
   assign time_base  = (next_time_ff == '0) ? s1_now_ff : next_time_ff;

   assign step_req.mode  = mode_ff;
   assign step_req.dir   = dir_ff;
   assign step_req.phase = phase_ff;
   assign step_req.pins  = pins_ff;

   sps_phase_step u_phase_step (
      .step_req (step_req),
      .step_rsp (step_rsp)
   );

   // next state on a step, hold otherwise
   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      next_time_in  = next_time_ff;
      pins_in       = pins_ff;
      rsp_pulsed_in = 1'b0;
      if (fire) begin
         phase_in      = step_rsp.phase;
         pins_in       = step_rsp.pins;
         remaining_in  = remaining_ff - sps_pkg::COUNT_WIDTH'(1);
         next_time_in  = time_base + sps_pkg::TIME_WIDTH'(period_eff);
         rsp_pulsed_in = 1'b1;
      end
      rsp_done_in = (remaining_in == '0);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sps_pkg::MODE_FOUR;
         period_ff <= sps_pkg::PERIOD_WIDTH'(1);
         dir_ff    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            sps_pkg::CSR_PHASE_MODE:   mode_ff   <= csr_wdata[0];
            sps_pkg::CSR_PULSE_PERIOD: period_ff <= csr_wdata[sps_pkg::PERIOD_WIDTH-1:0];
            sps_pkg::CSR_MOVE_DIR:     dir_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequencer state: a move_count write reloads the count and the schedule
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         remaining_ff <= '0;
         next_time_ff <= '0;
         pins_ff      <= '0;
      end else if (csr_we && (csr_index == sps_pkg::CSR_MOVE_COUNT)) begin
         remaining_ff <= csr_wdata[sps_pkg::COUNT_WIDTH-1:0];
         next_time_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         next_time_ff <= next_time_in;
         pins_ff      <= pins_in;
      end
   end

   // input stage: hold the time stamp until it moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_now_ff <= sps_pkg::TIME_WIDTH'(req_now_us);
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pins_ff   <= pins_in;
         rsp_pulsed_ff <= rsp_pulsed_in;
         rsp_done_ff   <= rsp_done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_level = rsp_pins_ff[0];
   assign rsp_dir_level  = rsp_pins_ff[1];
   assign rsp_ms1_level  = rsp_pins_ff[2];
   assign rsp_ms2_level  = rsp_pins_ff[3];
   assign rsp_ms3_level  = rsp_pins_ff[4];
   assign rsp_pulsed     = rsp_pulsed_ff;
   assign rsp_done_res   = rsp_done_ff;

   // assertions
   `SPS_ASSERT(a_phase_in_range, clock, reset, phase_ff < sps_pkg::PHASES_TEN)
   `SPS_ASSERT(a_step_counts_down, clock, reset,
      (advance && fire && !csr_we) |=> (remaining_ff == $past(remaining_ff) - 31'd1))
   `SPS_ASSERT(a_four_phase_keeps_ms, clock, reset,
      (advance && fire && !csr_we && (mode_ff == sps_pkg::MODE_FOUR))
         |=> ($stable(pins_ff[4:2])))
   `SPS_ASSERT_ALWAYS(a_no_result_in_reset, clock,
      $past(reset) |-> (!rsp_valid_ff && !s1_valid_ff))

endmodule
